// ===== rtl/sws_pkg.sv =====
// Shared types and constants for the sliding window sender.
// No dependencies; every other file in rtl/ depends on this package.
package sws_pkg;

  localparam int SEQ_SPACE   = 8;
  localparam int WINDOW_SIZE = 4;
  localparam int SEQ_W       = $clog2(SEQ_SPACE);
  localparam int THR_W       = 3;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int REG_IDX_W   = CFG_AW - 2;

  localparam logic [THR_W-1:0] DUP_THR_RESET = THR_W'(3);

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [THR_W-1:0] thr_t;

  typedef enum logic [1:0] {
    MODE_SEND    = 2'd0,
    MODE_ACK     = 2'd1,
    MODE_TIMEOUT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    TMR_LEAVE   = 2'd0,
    TMR_RESTART = 2'd1,
    TMR_STOP    = 2'd2
  } tmr_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_DUP_THR = REG_IDX_W'(0)
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] mode;
    seq_t       ack_num;
    logic       ack_intact;
  } event_t;

  typedef struct packed {
    logic       accepted;
    logic       transmit;
    seq_t       transmit_seq;
    logic [1:0] timer_cmd;
    seq_t       window_base;
    seq_t       next_sequence;
  } result_t;

  typedef struct packed {
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
  } apb_req_t;

endpackage

// ===== rtl/sws_in_if.sv =====
// Event channel: one beat carries a send request, an ack or a timeout.
// Depends on sws_pkg for the sequence number type.
interface sws_in_if;
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  sws_pkg::seq_t    ack_num;
  logic             ack_intact;

  modport source (output valid, output mode, output ack_num, output ack_intact,
                  input ready);
  modport sink   (input valid, input mode, input ack_num, input ack_intact,
                  output ready);
endinterface

// ===== rtl/sws_out_if.sv =====
// Result channel: one beat per event with transmit and timer decisions.
// Depends on sws_pkg for the sequence number type.
interface sws_out_if;
  logic             valid;
  logic             ready;
  logic             accepted;
  logic             transmit;
  sws_pkg::seq_t    transmit_seq;
  logic [1:0]       timer_cmd;
  sws_pkg::seq_t    window_base;
  sws_pkg::seq_t    next_sequence;

  modport source (output valid, output accepted, output transmit, output transmit_seq,
                  output timer_cmd, output window_base, output next_sequence,
                  input ready);
  modport sink   (input valid, input accepted, input transmit, input transmit_seq,
                  input timer_cmd, input window_base, input next_sequence,
                  output ready);
endinterface

// ===== rtl/sliding_window_sender.sv =====
// Top level of the go-back-N sender window controller with fast retransmit.
// Depends on sws_pkg, sws_in_if, sws_out_if, sws_cfg and sws_window.
//
//   channel   direction  handshake               payload
//   in_ch     sink       valid/ready             mode, ack_num, ack_intact
//   out_ch    source     valid/ready             accepted, transmit, transmit_seq,
//                                                timer_cmd, window_base, next_sequence
//   cfg_*     slave      APB, pready tied high   dup_ack_threshold at byte 0
//
// Every event passes from the input beat into the input register, then through
// the decision logic into the result register.
// One event per cycle is sustained while out_ch does not stall; the window
// state registers close their update loop, which sets that rate.
// Reset (rst_n low, synchronous) empties both registers, zeroes base, next and
// the duplicate count, and loads the threshold with 3.
// When out_ch stalls, the result register holds, the input register holds its
// event and in_ch.ready drops only once both are full.
module sliding_window_sender (
  input  logic                        clk,
  input  logic                        rst_n,
  sws_in_if.sink                      in_ch,
  sws_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sws_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [sws_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [sws_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import sws_pkg::*;

  apb_req_t cfg_req;
  thr_t     dup_thr;

  logic     in_vld_r, in_vld_nxt;
  event_t   in_ev_r;
  logic     out_vld_r, out_vld_nxt;
  result_t  out_res_r;
  result_t  res;
  logic     advance;
  logic     in_rdy;
  logic     fire;

  // configuration port
  assign cfg_req.psel    = cfg_psel;
  assign cfg_req.penable = cfg_penable;
  assign cfg_req.pwrite  = cfg_pwrite;
  assign cfg_req.paddr   = cfg_paddr;
  assign cfg_req.pwdata  = cfg_pwdata;
  assign cfg_pready      = 1'b1;

  sws_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (cfg_req),
    .prdata  (cfg_prdata),
    .dup_thr (dup_thr)
  );

  // advance the input register whenever the result register is free or drains
  assign advance = !out_vld_r || out_ch.ready;
  assign fire    = in_vld_r && advance;
  assign in_rdy  = !in_vld_r || advance;
  assign in_ch.ready = in_rdy;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_rdy) begin
      in_vld_nxt = in_ch.valid;
    end
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers: capture a beat on input, a decision on fire
  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      in_ev_r.mode       <= in_ch.mode;
      in_ev_r.ack_num    <= in_ch.ack_num;
      in_ev_r.ack_intact <= in_ch.ack_intact;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  sws_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .ev      (in_ev_r),
    .dup_thr (dup_thr),
    .res     (res)
  );

  assign out_ch.valid         = out_vld_r;
  assign out_ch.accepted      = out_res_r.accepted;
  assign out_ch.transmit      = out_res_r.transmit;
  assign out_ch.transmit_seq  = out_res_r.transmit_seq;
  assign out_ch.timer_cmd     = out_res_r.timer_cmd;
  assign out_ch.window_base   = out_res_r.window_base;
  assign out_ch.next_sequence = out_res_r.next_sequence;
endmodule

// ===== rtl/sws_cfg.sv =====
// APB register file: holds the duplicate-ack threshold.
// Depends on sws_pkg for the request struct and register indexes.
module sws_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sws_pkg::apb_req_t          req,
  output logic [sws_pkg::CFG_DW-1:0] prdata,
  output sws_pkg::thr_t              dup_thr
);
  import sws_pkg::*;

  thr_t     dup_thr_r;
  thr_t     dup_thr_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(req.paddr[CFG_AW-1:2]);
  assign wr_en = req.psel && req.penable && req.pwrite;

  always_comb begin
    dup_thr_nxt = dup_thr_r;
    if (wr_en && idx == REG_DUP_THR) begin
      dup_thr_nxt = req.pwdata[THR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dup_thr_r <= DUP_THR_RESET;
    end else begin
      dup_thr_r <= dup_thr_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_DUP_THR: prdata = CFG_DW'(dup_thr_r);
      default:     prdata = '0;
    endcase
  end

  assign dup_thr = dup_thr_r;
endmodule

// ===== rtl/sws_window.sv =====
// Window state (base, next, duplicate count) and the per-event decision logic.
// Depends on sws_pkg for event/result structs and code enums.
module sws_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sws_pkg::event_t   ev,
  input  sws_pkg::thr_t     dup_thr,
  output sws_pkg::result_t  res
);
  import sws_pkg::*;

  localparam seq_t WIN = SEQ_W'(WINDOW_SIZE);
  localparam seq_t ONE = SEQ_W'(1);

  seq_t base_r, base_nxt;
  seq_t next_r, next_nxt;
  thr_t dup_r,  dup_nxt;

  seq_t ack_dist;
  seq_t ack_base;
  thr_t dup_inc;
  logic win_full;
  logic win_empty;

  assign win_full  = (next_r == seq_t'(base_r + WIN));
  assign win_empty = (base_r == next_r);
  assign ack_dist  = seq_t'(ev.ack_num - base_r);
  assign ack_base  = seq_t'(ev.ack_num + ONE);
  assign dup_inc   = thr_t'(dup_r + THR_W'(1));

  always_comb begin
    base_nxt         = base_r;
    next_nxt         = next_r;
    dup_nxt          = dup_r;
    res.accepted     = 1'b0;
    res.transmit     = 1'b0;
    res.transmit_seq = '0;
    res.timer_cmd    = TMR_LEAVE;
    case (mode_t'(ev.mode))
      MODE_SEND: begin
        if (!win_full) begin
          res.accepted     = 1'b1;
          res.transmit     = 1'b1;
          res.transmit_seq = next_r;
          if (win_empty) begin
            res.timer_cmd = TMR_RESTART;
          end
          next_nxt = seq_t'(next_r + ONE);
        end
      end
      MODE_ACK: begin
        if (!win_empty && ev.ack_intact) begin
          if (ack_dist < WIN) begin
            // slide the base past the acked number
            base_nxt      = ack_base;
            res.timer_cmd = (ack_base == next_r) ? TMR_STOP : TMR_RESTART;
          end else if (dup_inc == dup_thr) begin
            // fast retransmit of the oldest outstanding packet
            res.transmit     = 1'b1;
            res.transmit_seq = base_r;
            res.timer_cmd    = TMR_RESTART;
            dup_nxt          = '0;
          end else begin
            dup_nxt = dup_inc;
          end
        end
      end
      MODE_TIMEOUT: begin
        res.transmit     = 1'b1;
        res.transmit_seq = base_r;
        res.timer_cmd    = TMR_RESTART;
      end
      default: begin
      end
    endcase
    res.window_base   = base_nxt;
    res.next_sequence = next_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      next_r <= '0;
      dup_r  <= '0;
    end else if (fire) begin
      base_r <= base_nxt;
      next_r <= next_nxt;
      dup_r  <= dup_nxt;
    end
  end
endmodule

// ===== rtl/sws_checker.sv =====
// Port-level checks for sliding_window_sender, attached with a bind.
// Depends on sws_pkg for widths and timer codes.
module sws_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_accepted,
  input logic                        out_transmit,
  input logic [1:0]                  out_timer_cmd,
  input sws_pkg::seq_t               out_window_base,
  input sws_pkg::seq_t               out_next_sequence,
  input logic                        cfg_psel,
  input logic                        cfg_penable,
  input logic                        cfg_pwrite,
  input logic [sws_pkg::CFG_AW-1:0]  cfg_paddr,
  input logic [sws_pkg::CFG_DW-1:0]  cfg_pwdata,
  input logic [sws_pkg::CFG_DW-1:0]  cfg_prdata
);
  import sws_pkg::*;

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_window_base)
      && $stable(out_next_sequence) && $stable(out_transmit))
    else $error("stalled result changed");

  // an accepted send always transmits and never stops the timer
  a_send_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_transmit && out_timer_cmd != TMR_STOP)
    else $error("accepted send without transmit");

  // stop only when the ack drained the window
  a_stop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_timer_cmd == TMR_STOP
      |-> out_window_base == out_next_sequence && !out_transmit)
    else $error("timer stopped with packets outstanding");

  // threshold readback follows a write
  a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[CFG_AW-1:2] == REG_DUP_THR
      |=> cfg_paddr[CFG_AW-1:2] != REG_DUP_THR
        || cfg_prdata[THR_W-1:0] == $past(cfg_pwdata[THR_W-1:0]))
    else $error("threshold readback mismatch");
endmodule

bind sliding_window_sender sws_checker u_sws_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_accepted      (out_ch.accepted),
  .out_transmit      (out_ch.transmit),
  .out_timer_cmd     (out_ch.timer_cmd),
  .out_window_base   (out_ch.window_base),
  .out_next_sequence (out_ch.next_sequence),
  .cfg_psel          (cfg_psel),
  .cfg_penable       (cfg_penable),
  .cfg_pwrite        (cfg_pwrite),
  .cfg_paddr         (cfg_paddr),
  .cfg_pwdata        (cfg_pwdata),
  .cfg_prdata        (cfg_prdata)
);
